// File: hdl/salp_pkg.sv
package salp_pkg;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLAMP = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DLOAD = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_POST  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_FILT = 2'd0,
        PH_RATE = 2'd1,
        PH_MOVE = 2'd2,
        PH_REAL = 2'd3
    } phase_t;

    localparam logic [2:0] CFG_ANGLE_MIN     = 3'd0;
    localparam logic [2:0] CFG_ANGLE_MAX     = 3'd1;
    localparam logic [2:0] CFG_RATE_MIN      = 3'd2;
    localparam logic [2:0] CFG_RATE_MAX      = 3'd3;
    localparam logic [2:0] CFG_ACTUATOR_TAU  = 3'd4;
    localparam logic [2:0] CFG_SMOOTHING_TAU = 3'd5;

    localparam int DIV_STEPS = 28;
    localparam int CNT_W = 5;
    localparam logic [20:0] US_PER_S = 21'd1000000;

    typedef struct packed {
        logic   load;
        logic   clamp;
        logic   mul;
        logic   dload;
        logic   dstep;
        logic   post;
        logic   out_wr;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic is_reset;
        logic stau_zero;
        logic div_done;
    } stat_t;

    function automatic logic signed [31:0] lim(input logic signed [57:0] v,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        logic signed [57:0] lo_w;
        logic signed [57:0] hi_w;
        logic signed [57:0] t;
        lo_w = {{26{lo[31]}}, lo};
        hi_w = {{26{hi[31]}}, hi};
        t = (v < hi_w) ? v : hi_w;
        t = (t > lo_w) ? t : lo_w;
        return t[31:0];
    endfunction

endpackage

// File: hdl/salp_ctrl.sv
module salp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  salp_pkg::stat_t      stat,
    output salp_pkg::cmd_t       cmd
);

    salp_pkg::state_t state_reg, state_next;
    salp_pkg::phase_t phase_reg, phase_next;
    logic m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        cmd.phase = phase_reg;
        s_ready = 1'b0;
        case (state_reg)
            salp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = salp_pkg::ST_CLAMP;
                end
            end
            salp_pkg::ST_CLAMP: begin
                cmd.clamp = 1'b1;
                if (stat.is_reset) begin
                    state_next = salp_pkg::ST_OUT;
                end else if (stat.stau_zero) begin
                    phase_next = salp_pkg::PH_RATE;
                    state_next = salp_pkg::ST_MUL;
                end else begin
                    phase_next = salp_pkg::PH_FILT;
                    state_next = salp_pkg::ST_MUL;
                end
            end
            salp_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = salp_pkg::ST_DLOAD;
            end
            salp_pkg::ST_DLOAD: begin
                cmd.dload = 1'b1;
                state_next = salp_pkg::ST_DIV;
            end
            salp_pkg::ST_DIV: begin
                cmd.dstep = 1'b1;
                if (stat.div_done) begin
                    state_next = salp_pkg::ST_POST;
                end
            end
            salp_pkg::ST_POST: begin
                cmd.post = 1'b1;
                if (phase_reg == salp_pkg::PH_REAL) begin
                    state_next = salp_pkg::ST_OUT;
                end else begin
                    phase_next = salp_pkg::phase_t'(phase_reg + 2'd1);
                    state_next = salp_pkg::ST_MUL;
                end
            end
            salp_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_wr = 1'b1;
                    state_next = salp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = salp_pkg::ST_IDLE;
            end
        endcase
        m_valid_next = cmd.out_wr ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= salp_pkg::ST_IDLE;
            phase_reg   <= salp_pkg::PH_FILT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/salp_dp.sv
module salp_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_command,
    input  logic signed [31:0]  s_desired_angle,
    input  logic signed [31:0]  s_measured_angle,
    input  logic [19:0]         s_step_time,
    output logic signed [31:0]  m_filtered_target,
    output logic signed [31:0]  m_new_angle,
    output logic signed [31:0]  m_realized_rate,
    input  salp_pkg::cmd_t      cmd,
    output salp_pkg::stat_t     stat
);

    logic signed [31:0] amin_reg;
    logic [30:0]        amax_reg;
    logic signed [31:0] rmin_reg;
    logic [30:0]        rmax_reg;
    logic [23:0]        tau_reg;
    logic [23:0]        stau_reg;

    logic               cmd_reg;
    logic signed [31:0] des_reg;
    logic signed [31:0] meas_reg;
    logic [19:0]        dt_reg;
    logic signed [31:0] mc_reg;
    logic signed [31:0] dc_reg;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] next_reg;
    logic signed [31:0] real_reg;
    logic signed [55:0] prod_reg;
    logic               neg_reg;
    logic [24:0]        dvsr_reg;
    logic [55:0]        dvd_reg;
    logic [24:0]        rem_reg;
    logic [55:0]        quo_reg;
    logic [salp_pkg::CNT_W-1:0] cnt_reg;

    logic signed [31:0] ahi;
    logic signed [31:0] rhi;
    logic signed [31:0] mc_c;
    logic signed [31:0] dc_c;
    logic signed [33:0] mul_a;
    logic [20:0]        mul_b;
    logic [24:0]        dvsr_c;
    logic [55:0]        mag_c;
    logic [24:0]        rem_c;
    logic [55:0]        dvd_c;
    logic [55:0]        quo_c;
    logic [25:0]        trial;
    logic signed [57:0] qs;

    assign ahi = {1'b0, amax_reg};
    assign rhi = {1'b0, rmax_reg};
    assign mc_c = salp_pkg::lim({{26{meas_reg[31]}}, meas_reg}, amin_reg, ahi);
    assign dc_c = salp_pkg::lim({{26{des_reg[31]}}, des_reg}, amin_reg, ahi);

    always_comb begin
        case (cmd.phase)
            salp_pkg::PH_FILT: begin
                mul_a = {{2{dc_reg[31]}}, dc_reg} - {{2{tgt_reg[31]}}, tgt_reg};
                mul_b = {1'b0, dt_reg};
                dvsr_c = {1'b0, stau_reg} + {5'd0, dt_reg};
            end
            salp_pkg::PH_RATE: begin
                mul_a = {{2{tgt_reg[31]}}, tgt_reg} - {{2{mc_reg[31]}}, mc_reg};
                mul_b = salp_pkg::US_PER_S;
                dvsr_c = (tau_reg == 24'd0) ? 25'd1 : {1'b0, tau_reg};
            end
            salp_pkg::PH_MOVE: begin
                mul_a = {{2{rate_reg[31]}}, rate_reg};
                mul_b = {1'b0, dt_reg};
                dvsr_c = {4'd0, salp_pkg::US_PER_S};
            end
            salp_pkg::PH_REAL: begin
                mul_a = {{2{next_reg[31]}}, next_reg} - {{2{mc_reg[31]}}, mc_reg};
                mul_b = salp_pkg::US_PER_S;
                dvsr_c = {5'd0, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
                dvsr_c = 25'd1;
            end
        endcase
        mag_c = (prod_reg[55] ? 56'(-prod_reg) : 56'(prod_reg)) + {32'd0, dvsr_c[24:1]};
    end

    always_comb begin
        rem_c = rem_reg;
        dvd_c = dvd_reg;
        quo_c = quo_reg;
        for (int i = 0; i < 2; i++) begin
            trial = {rem_c, dvd_c[55]};
            dvd_c = {dvd_c[54:0], 1'b0};
            if (trial >= {1'b0, dvsr_reg}) begin
                trial = trial - {1'b0, dvsr_reg};
                quo_c = {quo_c[54:0], 1'b1};
            end else begin
                quo_c = {quo_c[54:0], 1'b0};
            end
            rem_c = trial[24:0];
        end
        qs = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amin_reg <= -32'sd16777216;
            amax_reg <= 31'd16777216;
            rmin_reg <= -32'sd16777216;
            rmax_reg <= 31'd16777216;
            tau_reg  <= 24'd100000;
            stau_reg <= 24'd50000;
            tgt_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    salp_pkg::CFG_ANGLE_MIN:     amin_reg <= cfg_data;
                    salp_pkg::CFG_ANGLE_MAX:     amax_reg <= cfg_data[30:0];
                    salp_pkg::CFG_RATE_MIN:      rmin_reg <= cfg_data;
                    salp_pkg::CFG_RATE_MAX:      rmax_reg <= cfg_data[30:0];
                    salp_pkg::CFG_ACTUATOR_TAU:  tau_reg  <= cfg_data[23:0];
                    salp_pkg::CFG_SMOOTHING_TAU: stau_reg <= cfg_data[23:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.clamp) begin
                if (cmd_reg) begin
                    tgt_reg <= mc_c;
                end else if (stau_reg == 24'd0) begin
                    tgt_reg <= dc_c;
                end
            end
            if (cmd.post && cmd.phase == salp_pkg::PH_FILT) begin
                tgt_reg <= salp_pkg::lim({{26{tgt_reg[31]}}, tgt_reg} + qs, amin_reg, ahi);
            end
            if (cmd.dload) begin
                cnt_reg <= salp_pkg::CNT_W'(salp_pkg::DIV_STEPS);
            end else if (cmd.dstep) begin
                cnt_reg <= cnt_reg - salp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_command;
            des_reg  <= s_desired_angle;
            meas_reg <= s_measured_angle;
            dt_reg   <= (s_step_time == 20'd0) ? 20'd1 : s_step_time;
        end
        if (cmd.clamp) begin
            mc_reg <= mc_c;
            dc_reg <= dc_c;
            if (cmd_reg) begin
                next_reg <= mc_c;
                real_reg <= '0;
            end
        end
        if (cmd.mul) begin
            prod_reg <= mul_a * $signed({1'b0, mul_b});
        end
        if (cmd.dload) begin
            neg_reg  <= prod_reg[55];
            dvsr_reg <= dvsr_c;
            dvd_reg  <= mag_c;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (cmd.dstep) begin
            dvd_reg <= dvd_c;
            rem_reg <= rem_c;
            quo_reg <= quo_c;
        end
        if (cmd.post) begin
            case (cmd.phase)
                salp_pkg::PH_RATE: rate_reg <= salp_pkg::lim(qs, rmin_reg, rhi);
                salp_pkg::PH_MOVE:
                    next_reg <= salp_pkg::lim({{26{mc_reg[31]}}, mc_reg} + qs, amin_reg, ahi);
                salp_pkg::PH_REAL:
                    real_reg <= salp_pkg::lim(qs, 32'sh80000000, 32'sh7fffffff);
                default: begin
                end
            endcase
        end
        if (cmd.out_wr) begin
            m_filtered_target <= tgt_reg;
            m_new_angle       <= next_reg;
            m_realized_rate   <= real_reg;
        end
    end

    assign stat.is_reset  = cmd_reg;
    assign stat.stau_zero = (stau_reg == 24'd0);
    assign stat.div_done  = (cnt_reg == salp_pkg::CNT_W'(1));

endmodule

// File: hdl/steer_actuator_lag_rate_limiter_top.sv
// Steering actuator lag with rate limit: each word on the input channel
// yields one result word. A control step runs a clamp step, four multiply and
// divide passes and an output step from acceptance to result (three passes
// when smoothing is off); a reset command runs only the clamp and output
// steps. The next word can be accepted in the cycle after the result is
// written. Most of a step is spent in the one shared divider, which retires
// two quotient bits a cycle over a 56-bit dividend. A new word is accepted
// while the previous result still waits on the output; once that word is
// finished it holds until the output drains. Configuration is always
// ready.
module steer_actuator_lag_rate_limiter_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [31:0] s_desired_angle,
    input  logic signed [31:0] s_measured_angle,
    input  logic [19:0]        s_step_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_filtered_target,
    output logic signed [31:0] m_new_angle,
    output logic signed [31:0] m_realized_rate
);

    salp_pkg::cmd_t  cmd;
    salp_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    salp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    salp_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_command         (s_command),
        .s_desired_angle   (s_desired_angle),
        .s_measured_angle  (s_measured_angle),
        .s_step_time       (s_step_time),
        .m_filtered_target (m_filtered_target),
        .m_new_angle       (m_new_angle),
        .m_realized_rate   (m_realized_rate),
        .cmd               (cmd),
        .stat              (stat)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_wr |=> m_valid)
        else $error("result written but not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dstep && stat.div_done |=> cmd.post)
        else $error("divider finished without post step");

endmodule
